// ----- rtl/core/sqrt_bisection_search_core_defines.svh -----
// ----------------------------------------------------------------------------
// sqrt_bisection_search_core_defines
// assertion macros shared by the bisection square root core
// ----------------------------------------------------------------------------
`ifndef SQRT_BISECTION_SEARCH_CORE_DEFINES_SVH
`define SQRT_BISECTION_SEARCH_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SBS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define SBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/sbs_pkg.sv -----
// ----------------------------------------------------------------------------
// sbs_pkg
// shared widths, defaults and controller/datapath interface types
// ----------------------------------------------------------------------------
package sbs_pkg;

    localparam int VAL_W           = 32;
    localparam int ROOT_W          = 25;
    localparam int COUNT_W         = 7;
    localparam int SQ_W            = 2 * VAL_W;
    localparam int DEF_MAX_GUESSES = 64;
    localparam int DEF_FRAC_BITS   = 16;

    localparam logic [VAL_W-1:0] TOL_RESET = VAL_W'(66);

    typedef struct packed {
        logic load;
        logic mid_en;
        logic sq_en;
        logic step_en;
        logic out_load;
        logic tol_wr;
    } sbs_cmd_t;

    typedef struct packed {
        logic conv;
        logic cap;
    } sbs_status_t;

endpackage

// ----- rtl/core/sbs_dpath.sv -----
// ----------------------------------------------------------------------------
// sbs_dpath
// bounds, midpoint, squarer, tolerance window and result registers
// ----------------------------------------------------------------------------
module sbs_dpath #(
    parameter int MAX_GUESSES = sbs_pkg::DEF_MAX_GUESSES,
    parameter int FRAC_BITS   = sbs_pkg::DEF_FRAC_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sbs_pkg::sbs_cmd_t            cmd,
    output sbs_pkg::sbs_status_t         status,
    input  logic [sbs_pkg::VAL_W-1:0]    radicand,
    input  logic [sbs_pkg::VAL_W-1:0]    tolerance,
    output logic [sbs_pkg::ROOT_W-1:0]   root,
    output logic [sbs_pkg::COUNT_W-1:0]  guess_count,
    output logic                         converged
);
    import sbs_pkg::*;

    localparam int TW     = VAL_W + FRAC_BITS;
    localparam int LW     = TW + 1;
    localparam int CW     = ((SQ_W > LW) ? SQ_W : LW) + 1;
    localparam int CNT_W  = $clog2(MAX_GUESSES + 1);
    localparam logic [VAL_W-1:0] ONE_VAL = VAL_W'(1) << FRAC_BITS;
    localparam logic [CNT_W-1:0] CAP_VAL = CNT_W'(MAX_GUESSES);

    logic [VAL_W-1:0]   tol_reg;
    logic [VAL_W-1:0]   low_reg, low_next;
    logic [VAL_W-1:0]   high_reg, high_next;
    logic [VAL_W-1:0]   mid_reg;
    logic [SQ_W-1:0]    sq_reg;
    logic [TW-1:0]      target_reg;
    logic [LW-1:0]      hi_lim_reg;
    logic signed [LW-1:0] lo_lim_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [ROOT_W-1:0]  root_reg;
    logic [COUNT_W-1:0] guess_count_reg;
    logic               converged_reg;

    logic [TW-1:0]      target_in;
    logic [TW-1:0]      tol_sh;
    logic [VAL_W:0]     bound_sum;
    logic [CW-1:0]      sq_ext;
    logic               sq_lt_target;
    logic               sq_gt_target;
    logic               in_window;

    // tolerance register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
        end
        else if (cmd.tol_wr)
        begin
            tol_reg <= tolerance;
        end
    end

    assign target_in = {radicand, {FRAC_BITS{1'b0}}};
    assign tol_sh    = {tol_reg, {FRAC_BITS{1'b0}}};
    assign bound_sum = {1'b0, low_reg} + {1'b0, high_reg};

    assign sq_ext       = CW'(sq_reg);
    assign sq_lt_target = sq_ext < CW'(target_reg);
    assign sq_gt_target = sq_ext > CW'(target_reg);
    assign in_window    = (sq_ext < CW'(hi_lim_reg))
                       && ($signed(sq_ext) > CW'(lo_lim_reg));

    always_comb
    begin
        low_next   = low_reg;
        high_next  = high_reg;
        count_next = count_reg;
        if (cmd.load)
        begin
            low_next   = '0;
            high_next  = (radicand > ONE_VAL) ? radicand : ONE_VAL;
            count_next = '0;
        end
        else if (cmd.step_en)
        begin
            if (sq_lt_target)
            begin
                low_next = mid_reg;
            end
            if (sq_gt_target)
            begin
                high_next = mid_reg;
            end
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        low_reg   <= low_next;
        high_reg  <= high_next;
        count_reg <= count_next;
        if (cmd.load)
        begin
            target_reg <= target_in;
            hi_lim_reg <= {1'b0, target_in} + {1'b0, tol_sh};
            lo_lim_reg <= $signed({1'b0, target_in} - {1'b0, tol_sh});
        end
        if (cmd.mid_en)
        begin
            mid_reg <= bound_sum[VAL_W:1];
        end
        if (cmd.sq_en)
        begin
            sq_reg <= mid_reg * mid_reg;
        end
        if (cmd.out_load)
        begin
            root_reg        <= mid_reg[ROOT_W-1:0];
            guess_count_reg <= COUNT_W'(count_reg);
            converged_reg   <= in_window;
        end
    end

    assign status.conv = in_window;
    assign status.cap  = (count_reg == CAP_VAL);

    assign root        = root_reg;
    assign guess_count = guess_count_reg;
    assign converged   = converged_reg;

endmodule

// ----- rtl/core/sbs_ctrl.sv -----
// ----------------------------------------------------------------------------
// sbs_ctrl
// search sequencer and request handshakes
// ----------------------------------------------------------------------------
`include "sqrt_bisection_search_core_defines.svh"

module sbs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    output sbs_pkg::sbs_cmd_t    cmd,
    input  sbs_pkg::sbs_status_t status
);
    import sbs_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MID  = 5'b00010,
        ST_SQR  = 5'b00100,
        ST_EVAL = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   idle;
    logic   in_accept;
    logic   out_accept;

    assign idle       = (state_reg == ST_IDLE);
    assign in_stall   = !idle;
    assign cfg_ready  = idle;
    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid_reg && !out_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.tol_wr = cfg_valid && cfg_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MID;
                end
            end
            ST_MID:
            begin
                cmd.mid_en = 1'b1;
                state_next = ST_SQR;
            end
            ST_SQR:
            begin
                cmd.sq_en  = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (status.conv || status.cap)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.step_en = 1'b1;
                    state_next  = ST_MID;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_accept)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `SBS_ASSERT_NOW(a_no_overwrite, clk, rst_n, cmd.out_load, (!out_valid_reg || !out_stall), "result overwritten while pending")
    `SBS_ASSERT_NOW(a_step_only_open, clk, rst_n, cmd.step_en, (!status.conv && !status.cap), "step taken after search end")
    `SBS_ASSERT_NEXT(a_accept_starts, clk, rst_n, in_accept, (state_reg == ST_MID), "accepted request did not start search")
    `SBS_ASSERT_NOW(a_cfg_when_idle, clk, rst_n, cmd.tol_wr, (state_reg == ST_IDLE && !cmd.step_en), "tolerance written during search")

endmodule

// ----- rtl/core/sqrt_bisection_search_core.sv -----
// ----------------------------------------------------------------------------
// sqrt_bisection_search_core
// square root of an unsigned fixed point value by interval bisection
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  input     in_valid / in_stall    radicand
//  output    out_valid / out_stall  root, guess_count, converged
//  config    cfg_valid / cfg_ready  tolerance
//
//  each bisection step passes through the midpoint, squarer and window compare states
//  the result register lets the next request start while a result is pending
//  in_stall is high from acceptance until the result enters the output register
//  reset sets tolerance to 66 and empties the output register
// ----------------------------------------------------------------------------
module sqrt_bisection_search_core #(
    parameter int MAX_GUESSES = sbs_pkg::DEF_MAX_GUESSES,
    parameter int FRAC_BITS   = sbs_pkg::DEF_FRAC_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [sbs_pkg::VAL_W-1:0]    radicand,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [sbs_pkg::ROOT_W-1:0]   root,
    output logic [sbs_pkg::COUNT_W-1:0]  guess_count,
    output logic                         converged,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [sbs_pkg::VAL_W-1:0]    tolerance
);
    import sbs_pkg::*;

    sbs_cmd_t    cmd;
    sbs_status_t status;

    sbs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cmd       (cmd),
        .status    (status)
    );

    sbs_dpath #(
        .MAX_GUESSES (MAX_GUESSES),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .radicand    (radicand),
        .tolerance   (tolerance),
        .root        (root),
        .guess_count (guess_count),
        .converged   (converged)
    );

endmodule

// ----- tb/sv/tb_sqrt_bisection_search_core.sv -----
// ----------------------------------------------------------------------------
// tb_sqrt_bisection_search_core
// self-checking bench for the bisection square root core
// ----------------------------------------------------------------------------
//  requests are queued by the stimulus process and presented by a clocked
//  driver with random gaps; a clocked monitor stalls the result channel at
//  random and checks each result against a bit-exact bisection predictor
//  the tolerance register is rewritten between phases, once the core has
//  drained, and swept over zero, one, the maximum and random settings
// ----------------------------------------------------------------------------
module tb_sqrt_bisection_search_core;

    timeunit 1ns;
    timeprecision 1ps;

    import sbs_pkg::*;

    localparam int GUESS_CAP   = DEF_MAX_GUESSES;
    localparam int FRAC        = DEF_FRAC_BITS;
    localparam int IDLE_LIMIT  = 4000;
    localparam int DRAIN_WAIT  = 3 * (GUESS_CAP + 1) + 8;

    typedef struct packed {
        logic [ROOT_W-1:0]  root;
        logic [COUNT_W-1:0] guesses;
        logic               conv;
    } sqrt_result_t;

    typedef struct packed {
        logic [VAL_W-1:0] x;
        sqrt_result_t     res;
    } sqrt_expect_t;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                in_valid    = 1'b0;
    logic                in_stall;
    logic [VAL_W-1:0]    radicand    = '0;
    logic                out_valid;
    logic                out_stall   = 1'b1;
    logic [ROOT_W-1:0]   root;
    logic [COUNT_W-1:0]  guess_count;
    logic                converged;
    logic                cfg_valid   = 1'b0;
    logic                cfg_ready;
    logic [VAL_W-1:0]    tolerance   = '0;

    logic [VAL_W-1:0]    pending_radicands[$];
    sqrt_expect_t        expected_roots[$];
    logic [VAL_W-1:0]    tol_setting = TOL_RESET;
    int                  error_count = 0;
    int                  idle_cycles = 0;
    int                  send_gap    = 0;
    int                  send_streak = 0;
    int                  stall_left  = 0;
    int                  stall_streak = 0;

    sqrt_bisection_search_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .radicand    (radicand),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .root        (root),
        .guess_count (guess_count),
        .converged   (converged),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .tolerance   (tolerance)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic sqrt_result_t bisect_sqrt(input logic [VAL_W-1:0] x,
                                                 input logic [VAL_W-1:0] tol_q);
        logic [63:0]  one_q;
        logic [63:0]  target;
        logic [63:0]  tol_w;
        logic [63:0]  lo;
        logic [63:0]  hi;
        logic [63:0]  mid;
        logic [63:0]  sq;
        logic [63:0]  diff;
        int           steps;
        sqrt_result_t res;
        one_q  = 64'd1 << FRAC;
        target = 64'(x) << FRAC;
        tol_w  = 64'(tol_q) << FRAC;
        lo     = '0;
        hi     = (64'(x) > one_q) ? 64'(x) : one_q;
        mid    = (lo + hi) >> 1;
        sq     = mid * mid;
        diff   = (sq >= target) ? sq - target : target - sq;
        steps  = 0;
        while (diff >= tol_w && steps < GUESS_CAP)
        begin
            if (sq < target)
                lo = mid;
            if (sq > target)
                hi = mid;
            mid   = (lo + hi) >> 1;
            sq    = mid * mid;
            diff  = (sq >= target) ? sq - target : target - sq;
            steps = steps + 1;
        end
        res.root    = mid[ROOT_W-1:0];
        res.guesses = COUNT_W'(steps);
        res.conv    = (diff < tol_w);
        return res;
    endfunction

    // mostly short gaps, a few long ones, and runs with none at all
    function automatic int draw_gap(inout int streak);
        int pick;
        if (streak > 0)
        begin
            streak = streak - 1;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 4)
        begin
            streak = $urandom_range(10, 40);
            return 0;
        end
        if (pick < 50)
            return 0;
        if (pick < 88)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 20);
        return $urandom_range(50, 300);
    endfunction

    function automatic logic [VAL_W-1:0] pick_radicand();
        logic [63:0] mask;
        logic [31:0] k;
        case ($urandom_range(0, 5))
            0: return $urandom;
            1:
            begin
                mask = (64'd1 << $urandom_range(1, VAL_W)) - 64'd1;
                return $urandom & mask[VAL_W-1:0];
            end
            2:
            begin
                k = $urandom_range(0, 65535);
                return k * k;
            end
            3: return $urandom_range(0, 32'h0002_0000);
            4: return 32'hFFFF_FFFF - $urandom_range(0, 1000);
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    task automatic report_error(input string msg);
        $display("[%0t] %s", $time, msg);
        error_count = error_count + 1;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            radicand <= '0;
            send_gap <= 0;
        end
        else if (in_valid && !in_stall)
        begin
            expected_roots.push_back({radicand, bisect_sqrt(radicand, tol_setting)});
            if (draw_gap(send_streak) == 0 && pending_radicands.size() != 0)
            begin
                radicand <= pending_radicands.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
                send_gap <= draw_gap(send_streak);
            end
        end
        else if (!in_valid)
        begin
            if (send_gap > 0)
                send_gap <= send_gap - 1;
            else if (pending_radicands.size() != 0)
            begin
                in_valid <= 1'b1;
                radicand <= pending_radicands.pop_front();
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        sqrt_expect_t want;
        if (!rst_n)
        begin
            out_stall  <= 1'b1;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_roots.size() == 0)
                    report_error($sformatf("result with nothing pending: root %0h", root));
                else
                begin
                    want = expected_roots.pop_front();
                    if (root !== want.res.root)
                        report_error($sformatf("x %0h root: expected %0h, got %0h",
                                               want.x, want.res.root, root));
                    if (guess_count !== want.res.guesses)
                        report_error($sformatf("x %0h guess_count: expected %0d, got %0d",
                                               want.x, want.res.guesses, guess_count));
                    if (converged !== want.res.conv)
                        report_error($sformatf("x %0h converged: expected %0b, got %0b",
                                               want.x, want.res.conv, converged));
                end
            end
            if (stall_left > 0)
            begin
                out_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else
            begin
                stall_left <= draw_gap(stall_streak);
                out_stall  <= 1'b0;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
            || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_radicands.size() != 0 || in_valid || expected_roots.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_tolerance(input logic [VAL_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        tolerance <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        tol_setting = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_random(input int count);
        repeat (count) pending_radicands.push_back(pick_radicand());
    endtask

    task automatic run_phase(input logic [VAL_W-1:0] value, input int count);
        write_tolerance(value);
        pending_radicands.push_back(32'h0000_0000);
        pending_radicands.push_back(32'hFFFF_FFFF);
        pending_radicands.push_back(32'h0001_0000);
        queue_random(count);
        wait_drained();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset tolerance: extremes, exact squares, around one
        pending_radicands = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000,
                              32'h0000_FFFF, 32'h0001_0001, 32'h8000_0000, 32'h7FFF_FFFF,
                              32'h0004_0000, 32'h0009_0000, 32'h0000_0100, 32'h0000_4000,
                              32'h0019_0000, 32'hFFFE_0001, 32'h0000_0002, 32'h0002_0000,
                              32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_8000, 32'h00FF_FFFF,
                              32'h0064_0000, 32'hFFFF_0000};
        queue_random(130);
        wait_drained();

        // zero tolerance never passes, so every search hits the guess cap
        run_phase(32'h0000_0000, 13);
        run_phase(32'h0000_0001, 80);
        run_phase(32'hFFFF_FFFF, 80);
        run_phase($urandom_range(2, 2000), 150);
        run_phase($urandom, 100);
        run_phase(32'h0001_0000, 80);
        run_phase(TOL_RESET, 90);

        repeat (DRAIN_WAIT) @(posedge clk);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/sbs_pkg.sv
rtl/core/sbs_dpath.sv
rtl/core/sbs_ctrl.sv
rtl/core/sqrt_bisection_search_core.sv
tb/sv/tb_sqrt_bisection_search_core.sv
